>>> rtl/pfau_pkg.sv
// pfau_pkg: shared constants for the prime field arithmetic unit
// operation kinds, register indexes, reset values and default widths
// no dependencies
`default_nettype none
package pfau_pkg;
   localparam int ELEMENT_BITS_DEF  = 31;
   localparam int EXPONENT_BITS_DEF = 64;
   localparam int OPB_BITS          = 64;
   localparam int UNIT_BITS         = OPB_BITS + 1;
   localparam int CNT_BITS          = 6;

   localparam logic [2:0] KIND_ADD   = 3'd0;
   localparam logic [2:0] KIND_SUB   = 3'd1;
   localparam logic [2:0] KIND_MUL   = 3'd2;
   localparam logic [2:0] KIND_DIV   = 3'd3;
   localparam logic [2:0] KIND_POW   = 3'd4;
   localparam logic [2:0] KIND_INV   = 3'd5;
   localparam logic [2:0] KIND_ROOT  = 3'd6;
   localparam logic [2:0] KIND_IROOT = 3'd7;

   localparam logic REG_PRIME = 1'b0;
   localparam logic REG_GEN   = 1'b1;

   localparam longint unsigned PRIME_RESET = 64'd998244353;
   localparam longint unsigned GEN_RESET   = 64'd3;
endpackage
`default_nettype wire

>>> rtl/pfau_if.sv
// pfau channel interfaces: request and response handshakes with payload
// depends on pfau_pkg for the operand width
`default_nettype none
interface pfau_req_if #(parameter int ELEMENT_BITS = 31);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    kind;
   logic [ELEMENT_BITS-1:0]       operand_a;
   logic [pfau_pkg::OPB_BITS-1:0] operand_b;
   modport source (output valid, kind, operand_a, operand_b, input ready);
   modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface pfau_rsp_if #(parameter int ELEMENT_BITS = 31);
   logic                    valid;
   logic                    ready;
   logic [ELEMENT_BITS-1:0] result_value;
   logic                    bad_order;
   modport source (output valid, result_value, bad_order, input ready);
   modport sink (input valid, result_value, bad_order, output ready);
endinterface
`default_nettype wire

>>> rtl/pfau_step.sv
// pfau_step: shared add and conditional subtract unit
// computes x + y + cin, then removes d once when the sum reaches d
// depends on pfau_pkg
`default_nettype none
module pfau_step (
   input  wire logic [pfau_pkg::UNIT_BITS-1:0] x,
   input  wire logic [pfau_pkg::UNIT_BITS-1:0] y,
   input  wire logic                           cin,
   input  wire logic [pfau_pkg::UNIT_BITS-1:0] d,
   output logic      [pfau_pkg::UNIT_BITS-1:0] sum,
   output logic                                ge
);
   import pfau_pkg::*;
   logic [UNIT_BITS:0] raw;
   logic [UNIT_BITS:0] red;
   always_comb begin
      raw = {1'b0, x} + {1'b0, y} + {{UNIT_BITS{1'b0}}, cin};
      ge  = raw >= {1'b0, d};
      red = raw - {1'b0, d};
      sum = ge ? red[UNIT_BITS-1:0] : raw[UNIT_BITS-1:0];
   end
endmodule
`default_nettype wire

>>> rtl/prime_field_arithmetic_unit.sv
// channel   dir  payload
// req_if    in   kind, operand_a, operand_b
// rsp_if    out  result_value, bad_order
// csr_*     in   write enable, register index, write data
//
// one item at a time; a shared add/compare/subtract step does all the work
// reductions take ELEMENT_BITS steps (operand_b takes 64), a modular multiply
// takes 2*ELEMENT_BITS steps, a power runs max(EXPONENT_BITS, ELEMENT_BITS)
// square-and-multiply rounds, each a squaring and a multiply when the exponent
// bit is set; power, divide, inverse and root items all run such rounds
// synchronous reset sets the two registers to their reset values
// one output register holds the result until taken; the next item may be
// taken and run meanwhile, but cannot finish until that register is free
`default_nettype none
module prime_field_arithmetic_unit #(
   parameter int ELEMENT_BITS  = pfau_pkg::ELEMENT_BITS_DEF,
   parameter int EXPONENT_BITS = pfau_pkg::EXPONENT_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   pfau_req_if.sink                     req_if,
   pfau_rsp_if.source                   rsp_if,
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [ELEMENT_BITS-1:0] csr_wdata
);
   import pfau_pkg::*;

   localparam int W  = ELEMENT_BITS;
   localparam int XW = (EXPONENT_BITS > W) ? EXPONENT_BITS : W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_REDA = 4'd1;
   localparam logic [3:0] S_REDB = 4'd2;
   localparam logic [3:0] S_DISP = 4'd3;
   localparam logic [3:0] S_MDBL = 4'd4;
   localparam logic [3:0] S_MADD = 4'd5;
   localparam logic [3:0] S_PSQ  = 4'd6;
   localparam logic [3:0] S_PSQD = 4'd7;
   localparam logic [3:0] S_PMD  = 4'd8;
   localparam logic [3:0] S_PNX  = 4'd9;
   localparam logic [3:0] S_DIV2 = 4'd10;
   localparam logic [3:0] S_RDIV = 4'd11;
   localparam logic [3:0] S_RCHK = 4'd12;
   localparam logic [3:0] S_REDG = 4'd13;
   localparam logic [3:0] S_FIN  = 4'd14;
   localparam logic [3:0] S_OUT  = 4'd15;

   logic [3:0]           state_ff, state_in, mret_ff, mret_in, pret_ff, pret_in;
   logic [W-1:0]         p_ff, p_in, g_ff, g_in;
   logic [2:0]           kind_ff, kind_in;
   logic [W-1:0]         a_ff, a_in, b_ff, b_in;
   logic [OPB_BITS-1:0]  braw_ff, braw_in, sreg_ff, sreg_in;
   logic [UNIT_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in, pcnt_ff, pcnt_in;
   logic [W-1:0]         acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic [W-1:0]         pacc_ff, pacc_in, pbase_ff, pbase_in;
   logic [XW-1:0]        pe_ff, pe_in;
   logic [W-1:0]         q_ff, q_in;
   logic [W-1:0]         res_ff, res_in;
   logic                 bad_ff, bad_in, pfin_ff, pfin_in;
   logic                 ovalid_ff, ovalid_in;
   logic [W-1:0]         ores_ff, ores_in;
   logic                 obad_ff, obad_in;

   logic [UNIT_BITS-1:0] ux, uy, ud, uo;
   logic                 ucin, uge;
   logic [W-1:0]         pm1;
   logic                 is_root;

   pfau_step u_step (.x(ux), .y(uy), .cin(ucin), .d(ud), .sum(uo), .ge(uge));

   assign pm1     = p_ff - W'(1);
   assign is_root = (kind_ff == KIND_ROOT) || (kind_ff == KIND_IROOT);

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = ovalid_ff;
   assign rsp_if.result_value = ores_ff;
   assign rsp_if.bad_order    = obad_ff;

   // operand selection for the shared step
   always_comb begin
      ux   = '0;
      uy   = '0;
      ucin = 1'b0;
      ud   = UNIT_BITS'(p_ff);
      unique case (state_ff) inside
         S_REDA, S_REDB, S_REDG: begin
            ux   = rem_ff;
            uy   = rem_ff;
            ucin = sreg_ff[OPB_BITS-1];
         end
         S_RDIV: begin
            ux   = rem_ff;
            uy   = rem_ff;
            ucin = sreg_ff[OPB_BITS-1];
            ud   = {1'b0, braw_ff};
         end
         S_MDBL: begin
            ux = UNIT_BITS'(acc_ff);
            uy = UNIT_BITS'(acc_ff);
         end
         S_MADD: begin
            ux = UNIT_BITS'(acc_ff);
            uy = UNIT_BITS'(mx_ff);
         end
         S_DISP: begin
            ux = UNIT_BITS'(a_ff);
            uy = (kind_ff == KIND_SUB) ? UNIT_BITS'(p_ff) - UNIT_BITS'(b_ff)
                                       : UNIT_BITS'(b_ff);
         end
         default: begin
            ux = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mret_in   = mret_ff;
      pret_in   = pret_ff;
      p_in      = p_ff;
      g_in      = g_ff;
      kind_in   = kind_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      braw_in   = braw_ff;
      sreg_in   = sreg_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      pcnt_in   = pcnt_ff;
      acc_in    = acc_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      pacc_in   = pacc_ff;
      pbase_in  = pbase_ff;
      pe_in     = pe_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      bad_in    = bad_ff;
      pfin_in   = pfin_ff;
      ovalid_in = ovalid_ff && !rsp_if.ready;
      ores_in   = ores_ff;
      obad_in   = obad_ff;

      if (csr_we) begin
         if (csr_index == REG_PRIME) p_in = csr_wdata;
         else g_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in = req_if.kind;
               braw_in = req_if.operand_b;
               sreg_in = {req_if.operand_a, {(OPB_BITS-W){1'b0}}};
               rem_in  = '0;
               cnt_in  = CNT_BITS'(W-1);
               if (p_ff < W'(2)) begin
                  res_in   = '0;
                  bad_in   = (req_if.kind == KIND_ROOT) || (req_if.kind == KIND_IROOT);
                  state_in = S_OUT;
               end else begin
                  state_in = S_REDA;
               end
            end
         end
         S_REDA: begin
            rem_in  = uo;
            sreg_in = sreg_ff << 1;
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               a_in     = uo[W-1:0];
               rem_in   = '0;
               sreg_in  = braw_ff;
               cnt_in   = CNT_BITS'(OPB_BITS-1);
               state_in = S_REDB;
            end
         end
         S_REDB: begin
            rem_in  = uo;
            sreg_in = sreg_ff << 1;
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               b_in     = uo[W-1:0];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            bad_in = 1'b0;
            case (kind_ff) inside
               KIND_ADD, KIND_SUB: begin
                  res_in   = uo[W-1:0];
                  state_in = S_OUT;
               end
               KIND_MUL: begin
                  mx_in    = a_ff;
                  my_in    = b_ff;
                  acc_in   = '0;
                  cnt_in   = CNT_BITS'(W-1);
                  mret_in  = S_FIN;
                  pfin_in  = 1'b0;
                  state_in = S_MDBL;
               end
               KIND_DIV, KIND_POW, KIND_INV: begin
                  pacc_in  = W'(1);
                  pbase_in = (kind_ff == KIND_DIV) ? b_ff : a_ff;
                  pe_in    = (kind_ff == KIND_POW) ? XW'(braw_ff[EXPONENT_BITS-1:0])
                                                   : XW'(p_ff - W'(2));
                  pcnt_in  = CNT_BITS'(XW-1);
                  pret_in  = (kind_ff == KIND_DIV) ? S_DIV2 : S_FIN;
                  pfin_in  = 1'b1;
                  state_in = S_PSQ;
               end
               default: begin
                  if (braw_ff == '0) begin
                     res_in   = '0;
                     bad_in   = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     sreg_in  = {pm1, {(OPB_BITS-W){1'b0}}};
                     rem_in   = '0;
                     q_in     = '0;
                     cnt_in   = CNT_BITS'(W-1);
                     state_in = S_RDIV;
                  end
               end
            endcase
         end
         // modular multiply, multiplier bits msb first
         S_MDBL: begin
            acc_in   = uo[W-1:0];
            state_in = S_MADD;
         end
         S_MADD: begin
            if (my_ff[W-1]) acc_in = uo[W-1:0];
            my_in  = my_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
            state_in = (cnt_ff == '0) ? mret_ff : S_MDBL;
         end
         // square-and-multiply, exponent msb first
         S_PSQ: begin
            mx_in    = pacc_ff;
            my_in    = pacc_ff;
            acc_in   = '0;
            cnt_in   = CNT_BITS'(W-1);
            mret_in  = S_PSQD;
            state_in = S_MDBL;
         end
         S_PSQD: begin
            pacc_in = acc_ff;
            if (pe_ff[XW-1]) begin
               mx_in    = pbase_ff;
               my_in    = acc_ff;
               acc_in   = '0;
               cnt_in   = CNT_BITS'(W-1);
               mret_in  = S_PMD;
               state_in = S_MDBL;
            end else begin
               state_in = S_PNX;
            end
         end
         S_PMD: begin
            pacc_in  = acc_ff;
            state_in = S_PNX;
         end
         S_PNX: begin
            pe_in   = pe_ff << 1;
            pcnt_in = pcnt_ff - CNT_BITS'(1);
            state_in = (pcnt_ff == '0) ? pret_ff : S_PSQ;
         end
         S_DIV2: begin
            mx_in    = a_ff;
            my_in    = pacc_ff;
            acc_in   = '0;
            cnt_in   = CNT_BITS'(W-1);
            mret_in  = S_FIN;
            pfin_in  = 1'b0;
            state_in = S_MDBL;
         end
         // restoring division of p-1 by the root order
         S_RDIV: begin
            rem_in  = uo;
            q_in    = {q_ff[W-2:0], uge};
            sreg_in = sreg_ff << 1;
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) state_in = S_RCHK;
         end
         S_RCHK: begin
            if (rem_ff != '0) begin
               res_in   = '0;
               bad_in   = 1'b1;
               state_in = S_OUT;
            end else begin
               q_in     = (kind_ff == KIND_ROOT) ? q_ff : pm1 - q_ff;
               sreg_in  = {g_ff, {(OPB_BITS-W){1'b0}}};
               rem_in   = '0;
               cnt_in   = CNT_BITS'(W-1);
               state_in = S_REDG;
            end
         end
         S_REDG: begin
            rem_in  = uo;
            sreg_in = sreg_ff << 1;
            cnt_in  = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               pacc_in  = W'(1);
               pbase_in = uo[W-1:0];
               pe_in    = XW'(q_ff);
               pcnt_in  = CNT_BITS'(XW-1);
               pret_in  = S_FIN;
               pfin_in  = 1'b1;
               state_in = S_PSQ;
            end
         end
         S_FIN: begin
            res_in   = pfin_ff ? pacc_ff : acc_ff;
            state_in = S_OUT;
         end
         // hand the result to the output register once it is free
         S_OUT: begin
            if (!ovalid_ff || rsp_if.ready) begin
               ovalid_in = 1'b1;
               ores_in   = res_ff;
               obad_in   = bad_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         p_ff      <= W'(PRIME_RESET);
         g_ff      <= W'(GEN_RESET);
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p_ff      <= p_in;
         g_ff      <= g_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mret_ff  <= mret_in;
      pret_ff  <= pret_in;
      kind_ff  <= kind_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      braw_ff  <= braw_in;
      sreg_ff  <= sreg_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      pcnt_ff  <= pcnt_in;
      acc_ff   <= acc_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      pacc_ff  <= pacc_in;
      pbase_ff <= pbase_in;
      pe_ff    <= pe_in;
      q_ff     <= q_in;
      res_ff   <= res_in;
      bad_ff   <= bad_in;
      pfin_ff  <= pfin_in;
      ores_ff  <= ores_in;
      obad_ff  <= obad_in;
   end

`ifndef SYNTH
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("took a second item while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid &&
         $stable(rsp_if.result_value) && $stable(rsp_if.bad_order)))
      else $error("pending result changed or dropped");
   a_bad_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && bad_ff) |-> is_root)
      else $error("bad_order on a non-root kind");
   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && p_ff >= W'(2)) |-> (rsp_if.result_value < p_ff))
      else $error("result not reduced");
`endif
endmodule
`default_nettype wire
